// File: rtl/stq_pkg.sv
package stq_pkg;

  localparam int ID_W  = 8;
  localparam int DUR_W = 32;
  localparam int IVL_W = 16;

  localparam logic [IVL_W-1:0] IVL_RESET = 16'd10;

  localparam logic MODE_SLEEP = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  localparam logic STATUS_WOKEN  = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            status;
    logic            last;
  } result_t;

endpackage

// File: rtl/stq_front.sv
module stq_front #(
  parameter int TICK_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic                        mode,
  input  logic [stq_pkg::ID_W-1:0]    process_id,
  input  logic [stq_pkg::DUR_W-1:0]   duration_ms,
  input  logic [stq_pkg::IVL_W-1:0]   interval,
  output logic                        cmd_valid,
  input  logic                        cmd_ready,
  output logic [stq_pkg::ID_W+TICK_BITS:0] cmd_data
);

  localparam int DW     = stq_pkg::DUR_W;
  localparam int VW     = stq_pkg::IVL_W;
  localparam int QW     = DW + 1;
  localparam int STEP_W = $clog2(DW);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_DIV  = 2'd1;
  localparam logic [1:0] F_FIN  = 2'd2;
  localparam logic [1:0] F_SEND = 2'd3;

  logic [1:0]                state;
  logic [STEP_W-1:0]         step;
  logic [DW-1:0]             dvd;
  logic [VW-1:0]             rem;
  logic [VW-1:0]             dsr;
  logic                      is_tick;
  logic [stq_pkg::ID_W-1:0]  id;
  logic [TICK_BITS-1:0]      ticks;

  logic [VW:0]               shifted;
  logic                      fits;
  logic [VW:0]               diff;
  logic [QW-1:0]             q_ceil;
  logic                      over;

  // one restoring division step: shift in the next dividend bit, try to subtract
  assign shifted = {rem, dvd[DW-1]};
  assign fits    = shifted >= {1'b0, dsr};
  assign diff    = shifted - {1'b0, dsr};

  // round up and clamp to the tick range
  assign q_ceil = {1'b0, dvd} + QW'(rem != '0);
  assign over   = |q_ceil[QW-1:TICK_BITS];

  assign full      = (state != F_IDLE);
  assign cmd_valid = (state == F_SEND);
  assign cmd_data  = {is_tick, id, ticks};

  // sequence: accept, divide bit by bit, round, hand over; a tick goes straight to hand over
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (push) begin
            is_tick <= (mode == stq_pkg::MODE_TICK);
            id      <= process_id;
            dvd     <= duration_ms;
            rem     <= '0;
            dsr     <= (interval == '0) ? VW'(1) : interval;
            step    <= '0;
            state   <= (mode == stq_pkg::MODE_TICK) ? F_SEND : F_DIV;
          end
        end
        F_DIV: begin
          rem  <= fits ? diff[VW-1:0] : shifted[VW-1:0];
          dvd  <= {dvd[DW-2:0], fits};
          step <= step + STEP_W'(1);
          if (step == STEP_W'(DW - 1)) begin
            state <= F_FIN;
          end
        end
        F_FIN: begin
          ticks <= over ? '1 : q_ceil[TICK_BITS-1:0];
          state <= F_SEND;
        end
        F_SEND: begin
          if (cmd_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/stq_cmd_fifo.sv
module stq_cmd_fifo #(
  parameter int WIDTH = 41
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic [WIDTH-1:0] slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             wr_en;
  logic             rd_en;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = slot[rd_ptr];
  assign wr_en     = in_valid && in_ready;
  assign rd_en     = out_valid && out_ready;

  // store incoming commands
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot[wr_ptr] <= in_data;
    end
  end

  // advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      if (wr_en && !rd_en) begin
        count <= count + 2'd1;
      end else if (rd_en && !wr_en) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// File: rtl/stq_back.sv
module stq_back #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TICK_BITS   = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  output logic                       cmd_pop,
  input  logic                       cmd_is_tick,
  input  logic [stq_pkg::ID_W-1:0]   cmd_id,
  input  logic [TICK_BITS-1:0]       cmd_ticks,
  output logic                       res_valid,
  input  logic                       res_pop,
  output stq_pkg::result_t           res
);

  localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int NEXT_IDX = (QUEUE_DEPTH > 1) ? 1 : 0;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WAKE = 1'b1;

  logic                      state;
  logic [CNT_W-1:0]          count;
  logic [stq_pkg::ID_W-1:0]  cell_id    [QUEUE_DEPTH];
  logic [TICK_BITS-1:0]      cell_ticks [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]    after;

  logic             q_full;
  logic             out_free;
  logic             front_due;
  logic             dec;
  logic             shift;
  logic             insert;
  logic             emit;
  stq_pkg::result_t emit_res;

  assign q_full    = (count == CNT_W'(QUEUE_DEPTH));
  assign out_free  = !res_valid || res_pop;
  assign front_due = (count != '0) && (cell_ticks[0] == '0);

  // decide what the cell row does this cycle
  always_comb begin
    cmd_pop  = 1'b0;
    dec      = 1'b0;
    shift    = 1'b0;
    insert   = 1'b0;
    emit     = 1'b0;
    emit_res = '{id: cmd_id, status: stq_pkg::STATUS_REJECT, last: 1'b1};
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd_is_tick) begin
            cmd_pop = 1'b1;
            dec     = 1'b1;
          end else if (q_full) begin
            cmd_pop = out_free;
            emit    = out_free;
          end else begin
            cmd_pop = 1'b1;
            insert  = 1'b1;
          end
        end
      end
      ST_WAKE: begin
        if (front_due && out_free) begin
          shift    = 1'b1;
          emit     = 1'b1;
          emit_res = '{id: cell_id[0], status: stq_pkg::STATUS_WOKEN,
                       last: (count == CNT_W'(1)) || (cell_ticks[NEXT_IDX] != '0)};
        end
      end
      default: ;
    endcase
  end

  // sequencer state and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (dec) begin
            state <= ST_WAKE;
          end
        end
        ST_WAKE: begin
          if (!front_due) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (insert) begin
        count <= count + CNT_W'(1);
      end else if (shift) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // sorted cell row: decrement, drop the front, or open a slot for the new entry
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    localparam int UP = (g + 1 < QUEUE_DEPTH) ? g + 1 : g;
    localparam int DN = (g > 0) ? g - 1 : 0;

    assign after[g] = (CNT_W'(g) >= count) || (cell_ticks[g] > cmd_ticks);

    always_ff @(posedge clk) begin
      if (dec) begin
        if (cell_ticks[g] != '0) begin
          cell_ticks[g] <= cell_ticks[g] - TICK_BITS'(1);
        end
      end else if (shift) begin
        cell_id[g]    <= cell_id[UP];
        cell_ticks[g] <= cell_ticks[UP];
      end else if (insert && after[g]) begin
        if (g == 0 || !after[DN]) begin
          cell_id[g]    <= cmd_id;
          cell_ticks[g] <= cmd_ticks;
        end else begin
          cell_id[g]    <= cell_id[DN];
          cell_ticks[g] <= cell_ticks[DN];
        end
      end
    end
  end

  // result register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (res_pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res <= emit_res;
    end
  end

endmodule

// File: rtl/sleep_timer_queue_unit.sv
// Channel   | Direction | Handshake           | Payload
// ----------+-----------+---------------------+---------------------------------
// input     | in        | push / full         | mode, process_id, duration_ms
// result    | out       | pop / empty         | result_id, status, last
// config    | in        | cfg_write           | cfg_data (tick_interval_ms)
//
// A sleep request passes through the front one bit a cycle through the
// 32-step divider, then rounding and handover; a tick goes straight to
// handover. The cell row inserts a sleeper into its sorted place; a tick
// decrements every cell, then wakes the due ids in order as results are taken.
// Reset clears all control state; the interval returns to 10 ms.
// Either side stalls on its own: a two-entry command queue sits between them.
module sleep_timer_queue_unit #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TICK_BITS   = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic                        mode,
  input  logic [stq_pkg::ID_W-1:0]    process_id,
  input  logic [stq_pkg::DUR_W-1:0]   duration_ms,
  output logic                        empty,
  input  logic                        pop,
  output logic [stq_pkg::ID_W-1:0]    result_id,
  output logic                        status,
  output logic                        last,
  input  logic                        cfg_write,
  input  logic [stq_pkg::IVL_W-1:0]   cfg_data
);

  localparam int CMD_W = 1 + stq_pkg::ID_W + TICK_BITS;

  logic [stq_pkg::IVL_W-1:0] tick_interval_ms;
  logic                      f_valid;
  logic                      f_ready;
  logic [CMD_W-1:0]          f_data;
  logic                      q_valid;
  logic                      q_pop;
  logic [CMD_W-1:0]          q_data;
  logic                      res_valid;
  stq_pkg::result_t          res;

  // interval register
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_interval_ms <= stq_pkg::IVL_RESET;
    end else if (cfg_write) begin
      tick_interval_ms <= cfg_data;
    end
  end

  stq_front #(
    .TICK_BITS (TICK_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .mode        (mode),
    .process_id  (process_id),
    .duration_ms (duration_ms),
    .interval    (tick_interval_ms),
    .cmd_valid   (f_valid),
    .cmd_ready   (f_ready),
    .cmd_data    (f_data)
  );

  stq_cmd_fifo #(
    .WIDTH (CMD_W)
  ) u_cmd_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_data),
    .out_valid (q_valid),
    .out_ready (q_pop),
    .out_data  (q_data)
  );

  stq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TICK_BITS   (TICK_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (q_valid),
    .cmd_pop     (q_pop),
    .cmd_is_tick (q_data[CMD_W-1]),
    .cmd_id      (q_data[CMD_W-2:TICK_BITS]),
    .cmd_ticks   (q_data[TICK_BITS-1:0]),
    .res_valid   (res_valid),
    .res_pop     (pop),
    .res         (res)
  );

  assign empty     = !res_valid;
  assign result_id = res.id;
  assign status    = res.status;
  assign last      = res.last;

  // a rejected request is always the only result of its input
  a_reject_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && status == stq_pkg::STATUS_REJECT) |-> last)
    else $error("rejected result without last");

  // the front takes one item at a time
  a_front_busy: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> full)
    else $error("front accepted an item without going busy");

  // reset restores the default interval
  a_ivl_reset: assert property (@(posedge clk)
    rst |=> (tick_interval_ms == stq_pkg::IVL_RESET))
    else $error("interval not restored by reset");

endmodule

// File: sim/stq_checker.sv
module stq_checker #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  logic                      full,
  input  logic                      mode,
  input  logic [stq_pkg::ID_W-1:0]  process_id,
  input  logic [stq_pkg::DUR_W-1:0] duration_ms,
  input  logic                      empty,
  input  logic                      pop,
  input  logic [stq_pkg::ID_W-1:0]  result_id,
  input  logic                      status,
  input  logic                      last,
  input  logic                      cfg_write,
  input  logic [stq_pkg::IVL_W-1:0] cfg_data,
  output int                        mismatches,
  output int                        outstanding,
  output int                        items_taken,
  output int                        wakes_seen,
  output int                        rejects_seen,
  output int                        stall_cycles
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the sleeper list, front entry first
  logic [stq_pkg::ID_W-1:0]  sleeper_id    [QUEUE_DEPTH];
  logic [stq_pkg::DUR_W-1:0] sleeper_ticks [QUEUE_DEPTH];
  int                        sleepers;
  logic [stq_pkg::IVL_W-1:0] interval;
  stq_pkg::result_t          due_results [$];

  // Round the sleep time up to whole ticks; a zero interval counts as one
  function automatic logic [stq_pkg::DUR_W-1:0] ms_to_ticks(
    logic [stq_pkg::DUR_W-1:0] ms);
    logic [stq_pkg::DUR_W-1:0] divisor;
    logic [stq_pkg::DUR_W-1:0] whole;
    divisor = (interval == '0) ? stq_pkg::DUR_W'(1) : stq_pkg::DUR_W'(interval);
    whole = ms / divisor;
    if ((ms % divisor) != '0) whole = whole + 1'b1;
    return whole;
  endfunction

  // Insert behind every sleeper with an equal or smaller count, or reject when full
  task automatic queue_sleeper(logic [stq_pkg::ID_W-1:0] id,
                               logic [stq_pkg::DUR_W-1:0] ms);
    logic [stq_pkg::DUR_W-1:0] ticks;
    int                        pos;
    stq_pkg::result_t          reject;
    if (sleepers >= QUEUE_DEPTH) begin
      reject.id     = id;
      reject.status = stq_pkg::STATUS_REJECT;
      reject.last   = 1'b1;
      due_results.push_back(reject);
      return;
    end
    ticks = ms_to_ticks(ms);
    pos = 0;
    while (pos < sleepers && sleeper_ticks[pos] <= ticks) pos++;
    for (int i = sleepers; i > pos; i--) begin
      sleeper_id[i]    = sleeper_id[i-1];
      sleeper_ticks[i] = sleeper_ticks[i-1];
    end
    sleeper_id[pos]    = id;
    sleeper_ticks[pos] = ticks;
    sleepers++;
  endtask

  // Count every sleeper down, then release the leading run that reached zero
  task automatic tick_sleepers();
    int               woken;
    stq_pkg::result_t wake;
    for (int i = 0; i < sleepers; i++)
      if (sleeper_ticks[i] != '0) sleeper_ticks[i] = sleeper_ticks[i] - 1'b1;
    woken = 0;
    while (woken < sleepers && sleeper_ticks[woken] == '0) woken++;
    for (int i = 0; i < woken; i++) begin
      wake.id     = sleeper_id[i];
      wake.status = stq_pkg::STATUS_WOKEN;
      wake.last   = (i == woken - 1);
      due_results.push_back(wake);
    end
    for (int i = woken; i < sleepers; i++) begin
      sleeper_id[i-woken]    = sleeper_id[i];
      sleeper_ticks[i-woken] = sleeper_ticks[i];
    end
    sleepers -= woken;
  endtask

  // Compare one result transfer against the oldest expectation
  task automatic check_result();
    stq_pkg::result_t seen;
    stq_pkg::result_t want;
    seen.id     = result_id;
    seen.status = status;
    seen.last   = last;
    if (seen.status == stq_pkg::STATUS_REJECT) rejects_seen++;
    else wakes_seen++;
    if (due_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected result id=%0h status=%0b last=%0b",
                 $realtime, seen.id, seen.status, seen.last);
      return;
    end
    want = due_results.pop_front();
    if (seen.id !== want.id || seen.status !== want.status ||
        seen.last !== want.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"%0t: result mismatch: expected id=%0h status=%0b last=%0b, ",
                  "got id=%0h status=%0b last=%0b"},
                 $realtime, want.id, want.status, want.last,
                 seen.id, seen.status, seen.last);
    end
  endtask

  // Follow every transfer on the rising edge
  always @(posedge clk) begin
    if (rst) begin
      sleepers     = 0;
      interval     = stq_pkg::IVL_RESET;
      due_results.delete();
      mismatches   = 0;
      items_taken  = 0;
      wakes_seen   = 0;
      rejects_seen = 0;
      stall_cycles = 0;
    end else begin
      if (cfg_write) interval = cfg_data;
      if (push && full) stall_cycles++;
      if (push && !full) begin
        items_taken++;
        if (mode == stq_pkg::MODE_SLEEP) queue_sleeper(process_id, duration_ms);
        else tick_sleepers();
      end
      if (pop && !empty) check_result();
    end
    outstanding = due_results.size();
  end

endmodule

// File: sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 150;
  localparam int HOLD_CYCLES   = 800;

  logic                      clk;
  logic                      rst         = 1'b1;
  logic                      push        = 1'b0;
  logic                      full;
  logic                      mode        = stq_pkg::MODE_SLEEP;
  logic [stq_pkg::ID_W-1:0]  process_id  = '0;
  logic [stq_pkg::DUR_W-1:0] duration_ms = '0;
  logic                      empty;
  logic                      pop         = 1'b0;
  logic [stq_pkg::ID_W-1:0]  result_id;
  logic                      status;
  logic                      last;
  logic                      cfg_write   = 1'b0;
  logic [stq_pkg::IVL_W-1:0] cfg_data    = '0;

  int                        send_gap_pct = 0;
  int                        pop_gap_pct  = 0;
  logic                      hold_pop     = 1'b0;
  logic [stq_pkg::IVL_W-1:0] interval_now = stq_pkg::IVL_RESET;
  int                        cycles       = 0;

  int chk_mismatches, chk_outstanding, chk_items, chk_wakes, chk_rejects, chk_stalls;

  sleep_timer_queue_unit #(
    .QUEUE_DEPTH(16),
    .TICK_BITS  (32)
  ) uut (
    .clk, .rst, .push, .full, .mode, .process_id, .duration_ms,
    .empty, .pop, .result_id, .status, .last, .cfg_write, .cfg_data
  );

  stq_checker #(
    .QUEUE_DEPTH(16)
  ) chk (
    .clk, .rst, .push, .full, .mode, .process_id, .duration_ms,
    .empty, .pop, .result_id, .status, .last, .cfg_write, .cfg_data,
    .mismatches  (chk_mismatches),
    .outstanding (chk_outstanding),
    .items_taken (chk_items),
    .wakes_seen  (chk_wakes),
    .rejects_seen(chk_rejects),
    .stall_cycles(chk_stalls)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycles, chk_outstanding);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Take results at a random rate; hold off entirely during a forced stall
  always @(negedge clk) begin
    pop <= !hold_pop && ($urandom_range(0, 99) >= pop_gap_pct);
  end

  // Offer one item after a random gap and hold it until the transfer
  task automatic offer(logic m, logic [stq_pkg::ID_W-1:0] id,
                       logic [stq_pkg::DUR_W-1:0] ms);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push        <= 1'b1;
    mode        <= m;
    process_id  <= id;
    duration_ms <= ms;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop offering, wait for every due result, then let the divider go quiet
  task automatic settle();
    push <= 1'b0;
    while (chk_outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_interval(logic [stq_pkg::IVL_W-1:0] value);
    cfg_write    <= 1'b1;
    cfg_data     <= value;
    interval_now = value;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Mix of ticks and sleeps mostly a few ticks long, with bursts of eight sleeps
  // and a rare full-width duration
  task automatic random_traffic(int count);
    int                        left;
    int                        pick;
    int                        burst;
    int unsigned               spread;
    logic [stq_pkg::DUR_W-1:0] ms;
    spread = ((interval_now == '0) ? 1 : int'(interval_now)) * 6;
    left = count;
    while (left > 0) begin
      pick = $urandom_range(0, 99);
      if (pick >= 5 && pick < 45) begin
        offer(stq_pkg::MODE_TICK, stq_pkg::ID_W'($urandom), stq_pkg::DUR_W'($urandom));
        left--;
      end else begin
        burst = (pick < 5) ? 8 : 1;
        repeat (burst) begin
          if ($urandom_range(0, 63) == 0) ms = $urandom;
          else ms = $urandom_range(0, spread);
          offer(stq_pkg::MODE_SLEEP, stq_pkg::ID_W'($urandom), ms);
          left--;
        end
      end
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty tick, field extremes, rounding, equal counts, fill and reject
    offer(stq_pkg::MODE_TICK,  8'h00, 32'd0);
    offer(stq_pkg::MODE_SLEEP, 8'h00, 32'd0);
    offer(stq_pkg::MODE_SLEEP, 8'hFF, 32'hFFFF_FFFF);
    offer(stq_pkg::MODE_SLEEP, 8'hA5, 32'd10);
    offer(stq_pkg::MODE_SLEEP, 8'h5A, 32'd11);
    offer(stq_pkg::MODE_SLEEP, 8'h33, 32'd9);
    offer(stq_pkg::MODE_SLEEP, 8'hCC, 32'd20);
    offer(stq_pkg::MODE_TICK,  8'hFF, 32'hFFFF_FFFF);
    offer(stq_pkg::MODE_TICK,  8'h00, 32'd0);
    for (int k = 0; k < 15; k++)
      offer(stq_pkg::MODE_SLEEP, 8'h10 + stq_pkg::ID_W'(k % 8),
            stq_pkg::DUR_W'((k % 4) * 10));
    offer(stq_pkg::MODE_SLEEP, 8'h99, 32'd5);
    settle();

    // Random at the widest interval: busy sender, slow receiver
    set_interval(16'hFFFF);
    send_gap_pct = 12;
    pop_gap_pct <= 88;
    random_traffic(38);
    settle();

    // Random at a zero interval: slow sender, busy receiver
    set_interval('0);
    send_gap_pct = 88;
    pop_gap_pct <= 12;
    random_traffic(38);
    settle();

    // Back up the result side until the block refuses input
    set_interval(16'd1);
    send_gap_pct = 0;
    pop_gap_pct <= 0;
    fork
      begin
        hold_pop <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_pop <= 1'b0;
      end
    join_none
    repeat (16) begin
      offer(stq_pkg::MODE_SLEEP, stq_pkg::ID_W'($urandom),
            stq_pkg::DUR_W'($urandom_range(0, 1)));
      offer(stq_pkg::MODE_TICK, stq_pkg::ID_W'($urandom), stq_pkg::DUR_W'($urandom));
    end
    settle();

    // Random at an arbitrary interval with no idling
    set_interval(stq_pkg::IVL_W'($urandom_range(2, 999)));
    random_traffic(38);
    settle();

    $display("Sent %0d sleeps and ticks at tick intervals 10, 65535, 0, 1 and %0d ms.",
             chk_items, interval_now);
    $display("Checked %0d wakes and %0d full-queue rejects; input stalled %0d cycles.",
             chk_wakes, chk_rejects, chk_stalls);
    if (chk_mismatches == 0 && chk_outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
